### sv/sfsu_pkg.sv
// Shared types and constants for the sensor FIFO sample unpack ring.
package sfsu_pkg;

   localparam int VALUE_W            = 18;
   localparam int PARTIAL_W          = 10;
   localparam int DEFAULT_RING_DEPTH = 4;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [1:0] ACTIVE_CH_RESET = 2'd2;
   localparam logic [1:0] PHASE_HIGH      = 2'd0;
   localparam logic [1:0] PHASE_MID       = 2'd1;
   localparam logic [1:0] PHASE_LOW       = 2'd2;
   localparam logic [1:0] CH_RED          = 2'd0;
   localparam logic [1:0] CH_IR           = 2'd1;
   localparam logic       CSR_IDX_ACTIVE  = 1'b0;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // per-store bit order: [0] red, [1] ir, [2] green
   typedef struct packed {
      logic                 pop_ok;
      logic                 done;
      logic [1:0]           unread;
      logic [2:0]           fwd;
      logic [VALUE_W-1:0]   fwd_value;
      logic [2:0]           new_vld;
      logic [2:0]           pop_vld;
   } s1_type;

endpackage

### sv/sfsu_ram.sv
// Generic RAM: one write port, two registered read ports.
module sfsu_ram #(
   parameter int WIDTH  = 18,
   parameter int DEPTH  = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sv/sensor_fifo_sample_unpack_ring_top.sv
// Sensor FIFO byte unpacker with a ring of red/IR/green samples.
//
// Input channel (req_): one transfer carries op and data_byte. A push assembles
// three bytes, most significant first, into an 18-bit channel value; red, IR
// and green values (active_channels of them) form one sample slot. A pop
// returns the oldest unread sample and advances the tail.
// Result channel (rsp_): exactly one transfer per accepted item, in order,
// with the newest slot, the popped sample, pop_ok, sample_done and the
// unread count after that item.
// Each result passes the read stage (sample RAM read) and then the output
// register before rsp_valid rises.
// Throughput: one item per cycle while the receiver does not stall, set by the
// write plus two-port read of the sample RAMs.
// When the receiver stalls, the output register and the RAM read stage fill,
// then req_stall rises; nothing is dropped.
// Reset clears indices, byte assembly and per-slot valid bits (unwritten slots
// read as zero); active_channels returns to 2 and lies at CSR byte address 0.
// The user must write it only while idle; the block does not enforce this.
module sensor_fifo_sample_unpack_ring_top
   import sfsu_pkg::*;
#(
   parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_newest_red,
   output logic [VALUE_W-1:0]    rsp_newest_ir,
   output logic [VALUE_W-1:0]    rsp_newest_green,
   output logic [VALUE_W-1:0]    rsp_popped_red,
   output logic [VALUE_W-1:0]    rsp_popped_ir,
   output logic [VALUE_W-1:0]    rsp_popped_green,
   output logic                  rsp_pop_ok,
   output logic                  rsp_sample_done,
   output logic [1:0]            rsp_unread_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(RING_DEPTH);
   localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + AW'(1);
   endfunction

   // control state
   logic [1:0]            ac_ff, ac_in;
   logic [1:0]            phase_ff, phase_in;
   logic [1:0]            ch_ff, ch_in;
   logic [PARTIAL_W-1:0]  part_ff, part_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [RING_DEPTH-1:0] vld_red_ff, vld_red_in;
   logic [RING_DEPTH-1:0] vld_ir_ff, vld_ir_in;
   logic [RING_DEPTH-1:0] vld_grn_ff, vld_grn_in;

   // read stage
   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] new_red_ff, new_ir_ff, new_grn_ff;
   logic [VALUE_W-1:0] pop_red_ff, pop_ir_ff, pop_grn_ff;
   logic               pop_ok_ff, done_ff;
   logic [1:0]         unread_ff;
   logic [VALUE_W-1:0] new_red, new_ir, new_grn;
   logic [VALUE_W-1:0] pop_red, pop_ir, pop_grn;

   logic               acc, s1_adv, csr_wr;
   logic [1:0]         chans, ch_next;
   logic [VALUE_W-1:0] value;
   logic               we_red, we_ir, we_grn, adv;
   logic [AW:0]        diff;

   logic [VALUE_W-1:0] red_a, red_b, ir_a, ir_b, grn_a, grn_b;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign acc       = req_valid && !req_stall;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ACTIVE) ? CSR_DATA_W'(ac_ff) : '0;

   assign chans = (ac_ff == 2'd0) ? 2'd1 : ac_ff;
   assign value = {part_ff, req_data_byte};

   always_comb begin
      ac_in      = ac_ff;
      phase_in   = phase_ff;
      ch_in      = ch_ff;
      part_in    = part_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      vld_red_in = vld_red_ff;
      vld_ir_in  = vld_ir_ff;
      vld_grn_in = vld_grn_ff;
      we_red     = 1'b0;
      we_ir      = 1'b0;
      we_grn     = 1'b0;
      adv        = 1'b0;
      diff       = '0;
      ch_next    = ch_ff + 2'd1;
      s1_in      = s1_ff;
      if (csr_wr && csr_paddr[2] == CSR_IDX_ACTIVE) begin
         ac_in = csr_pwdata[1:0];
      end
      if (acc) begin
         s1_in.pop_ok = 1'b0;
         s1_in.done   = 1'b0;
         if (op_type'(req_op) == OP_PUSH) begin
            case (phase_ff)
               PHASE_HIGH: begin
                  part_in  = {req_data_byte[1:0], 8'd0};
                  phase_in = PHASE_MID;
               end
               PHASE_MID: begin
                  part_in  = {part_ff[9:8], req_data_byte};
                  phase_in = PHASE_LOW;
               end
               default: begin
                  part_in  = '0;
                  phase_in = PHASE_HIGH;
                  case (ch_ff)
                     CH_RED: begin
                        adv     = 1'b1;
                        head_in = ring_next(head_ff);
                        if (ring_next(head_ff) == tail_ff) begin
                           tail_in = ring_next(tail_ff);
                        end
                        we_red = 1'b1;
                     end
                     CH_IR:   we_ir  = 1'b1;
                     default: we_grn = 1'b1;
                  endcase
                  if (ch_next >= chans || ch_next == 2'd0) begin
                     ch_in        = CH_RED;
                     s1_in.done   = 1'b1;
                  end else begin
                     ch_in = ch_next;
                  end
               end
            endcase
         end else if (head_ff != tail_ff) begin
            tail_in      = ring_next(tail_ff);
            s1_in.pop_ok = 1'b1;
         end
         if (we_red) vld_red_in[head_in] = 1'b1;
         if (we_ir)  vld_ir_in[head_in]  = 1'b1;
         if (we_grn) vld_grn_in[head_in] = 1'b1;
         diff = {1'b0, head_in} + ((head_in < tail_in) ? DEPTH_EXT : '0) - {1'b0, tail_in};
         s1_in.fwd       = {we_grn, we_ir, we_red};
         s1_in.fwd_value = value;
         s1_in.new_vld   = {vld_grn_ff[head_in], vld_ir_ff[head_in], vld_red_ff[head_in]};
         s1_in.pop_vld   = {vld_grn_ff[tail_in], vld_ir_ff[tail_in], vld_red_ff[tail_in]};
         s1_in.unread    = diff[1:0];
      end
   end

   assign s1_valid_in  = acc || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   sfsu_ram #(.WIDTH(VALUE_W), .DEPTH(RING_DEPTH)) u_red_ram (
      .clock(clock), .wr_en(we_red), .wr_addr(head_in), .wr_data(value),
      .rd_en(acc), .rd_addr_a(head_in), .rd_addr_b(tail_in),
      .rd_data_a(red_a), .rd_data_b(red_b)
   );

   sfsu_ram #(.WIDTH(VALUE_W), .DEPTH(RING_DEPTH)) u_ir_ram (
      .clock(clock), .wr_en(we_ir), .wr_addr(head_in), .wr_data(value),
      .rd_en(acc), .rd_addr_a(head_in), .rd_addr_b(tail_in),
      .rd_data_a(ir_a), .rd_data_b(ir_b)
   );

   sfsu_ram #(.WIDTH(VALUE_W), .DEPTH(RING_DEPTH)) u_grn_ram (
      .clock(clock), .wr_en(we_grn), .wr_addr(head_in), .wr_data(value),
      .rd_en(acc), .rd_addr_a(head_in), .rd_addr_b(tail_in),
      .rd_data_a(grn_a), .rd_data_b(grn_b)
   );

   // same-cycle write to the newest slot is forwarded past the RAM
   always_comb begin
      new_red = s1_ff.fwd[0] ? s1_ff.fwd_value : (s1_ff.new_vld[0] ? red_a : '0);
      new_ir  = s1_ff.fwd[1] ? s1_ff.fwd_value : (s1_ff.new_vld[1] ? ir_a : '0);
      new_grn = s1_ff.fwd[2] ? s1_ff.fwd_value : (s1_ff.new_vld[2] ? grn_a : '0);
      pop_red = (s1_ff.pop_ok && s1_ff.pop_vld[0]) ? red_b : '0;
      pop_ir  = (s1_ff.pop_ok && s1_ff.pop_vld[1]) ? ir_b : '0;
      pop_grn = (s1_ff.pop_ok && s1_ff.pop_vld[2]) ? grn_b : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_ff        <= ACTIVE_CH_RESET;
         phase_ff     <= PHASE_HIGH;
         ch_ff        <= CH_RED;
         part_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         vld_red_ff   <= '0;
         vld_ir_ff    <= '0;
         vld_grn_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ac_ff        <= ac_in;
         phase_ff     <= phase_in;
         ch_ff        <= ch_in;
         part_ff      <= part_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         vld_red_ff   <= vld_red_in;
         vld_ir_ff    <= vld_ir_in;
         vld_grn_ff   <= vld_grn_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_adv) begin
         new_red_ff <= new_red;
         new_ir_ff  <= new_ir;
         new_grn_ff <= new_grn;
         pop_red_ff <= pop_red;
         pop_ir_ff  <= pop_ir;
         pop_grn_ff <= pop_grn;
         pop_ok_ff  <= s1_ff.pop_ok;
         done_ff    <= s1_ff.done;
         unread_ff  <= s1_ff.unread;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_newest_red   = new_red_ff;
   assign rsp_newest_ir    = new_ir_ff;
   assign rsp_newest_green = new_grn_ff;
   assign rsp_popped_red   = pop_red_ff;
   assign rsp_popped_ir    = pop_ir_ff;
   assign rsp_popped_green = pop_grn_ff;
   assign rsp_pop_ok       = pop_ok_ff;
   assign rsp_sample_done  = done_ff;
   assign rsp_unread_count = unread_ff;

   a_done_pop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pop_ok && rsp_sample_done))
      else $error("sample_done and pop_ok both set");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pop_ok) |->
         (rsp_popped_red == '0 && rsp_popped_ir == '0 && rsp_popped_green == '0))
      else $error("popped fields nonzero without pop_ok");

   a_head_not_tail: assert property (@(posedge clock) disable iff (reset)
      (acc && adv) |=> (head_ff != tail_ff))
      else $error("ring head landed on tail after red write");

   a_empty_pop_hold: assert property (@(posedge clock) disable iff (reset)
      (acc && op_type'(req_op) == OP_POP && head_ff == tail_ff) |=>
         (tail_ff == $past(tail_ff) && head_ff == $past(head_ff)))
      else $error("pop of empty ring moved an index");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && s1_valid_ff))
      else $error("input stalled with free pipeline stage");

endmodule
